// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, off while rst_n is low.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Plain condition that must hold at every rising edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// File: rtl/mmu_pkg.sv
// Shared types and constants of the matrix multiply unit.
`default_nettype none

package mmu_pkg;

    // Fixed field widths.
    localparam int RES_W = 35;
    localparam int IDX_W = 3;
    localparam int DIM_W = 4;
    localparam int CMD_W = 2;
    localparam int VAL_W = 16;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROWS_A     = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_COLS_B     = 2'd2;

    // Control that travels with one multiply-accumulate step.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/matrix_multiply_unit.sv
// Compute: for each result element the sequencer waits until the output slot is free,
// then issues the clamped inner_size accumulate steps to the single multiply-accumulate unit,
// whose sum goes to the output register; loads are taken one per cycle while idle.
// The two element memories have one read port each, read once per accumulate step.
// Reset clears control state and sets the registers to 8; the stores are not cleared.
// Input is stalled for the whole compute, so loads never touch an entry being read.
`default_nettype none

module matrix_multiply_unit #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [3:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready,
    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [mmu_pkg::CMD_W-1:0]             cmd,
    input  wire logic [mmu_pkg::IDX_W-1:0]             row_index,
    input  wire logic [mmu_pkg::IDX_W-1:0]             col_index,
    input  wire logic signed [mmu_pkg::VAL_W-1:0]      element_value,
    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mmu_pkg::RES_W-1:0]           result_value,
    output logic [mmu_pkg::IDX_W-1:0]                  result_row,
    output logic [mmu_pkg::IDX_W-1:0]                  result_col,
    output logic                                       last_element
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [mmu_pkg::DIM_W-1:0] DIM_MAX = mmu_pkg::DIM_W'(MAX_DIM);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [mmu_pkg::DIM_W-1:0] rows_a_reg, inner_size_reg, cols_b_reg;
    logic [1:0]                state_reg, state_next;
    logic [mmu_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [mmu_pkg::DIM_W-1:0] nr_reg, nr_next, nk_reg, nk_next, nc_reg, nc_next;

    logic [ELEM_WIDTH-1:0]         store_a [DEPTH];
    logic [ELEM_WIDTH-1:0]         store_b [DEPTH];
    logic signed [ELEM_WIDTH-1:0]  rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]             rd_addr_a, rd_addr_b, wr_addr;
    logic [ELEM_WIDTH+mmu_pkg::VAL_W-1:0] wr_ext;
    logic [ELEM_WIDTH-1:0]         wr_elem;
    logic                          wr_in_range;

    mmu_pkg::mac_ctrl_t issue_ctrl, ctrl_rd_reg;
    logic                          mac_done;
    logic signed [mmu_pkg::RES_W-1:0] mac_sum;

    logic                          in_xfer, cfg_wr, out_xfer, out_free;
    logic                          k_last, j_last, i_last, elem_last;

    logic                              out_valid_reg;
    logic signed [mmu_pkg::RES_W-1:0]  result_value_reg;
    logic [mmu_pkg::IDX_W-1:0]         result_row_reg, result_col_reg;
    logic                              last_element_reg;

    // Clamp a dimension register into 1..MAX_DIM.
    function automatic logic [mmu_pkg::DIM_W-1:0] clamp_dim(
        input logic [mmu_pkg::DIM_W-1:0] r,
        input logic [mmu_pkg::DIM_W-1:0] dmax
    );
        logic [mmu_pkg::DIM_W-1:0] v;
        priority if (r == '0)
        begin
            v = mmu_pkg::DIM_W'(1);
        end
        else if (r > dmax)
        begin
            v = dmax;
        end
        else
        begin
            v = r;
        end
        return v;
    endfunction

    // Configuration registers.
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg     <= mmu_pkg::DIM_W'(8);
            inner_size_reg <= mmu_pkg::DIM_W'(8);
            cols_b_reg     <= mmu_pkg::DIM_W'(8);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                mmu_pkg::REG_ROWS_A:     rows_a_reg     <= pwdata[3:0];
                mmu_pkg::REG_INNER_SIZE: inner_size_reg <= pwdata[3:0];
                mmu_pkg::REG_COLS_B:     cols_b_reg     <= pwdata[3:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mmu_pkg::REG_ROWS_A:     prdata = {28'd0, rows_a_reg};
            mmu_pkg::REG_INNER_SIZE: prdata = {28'd0, inner_size_reg};
            mmu_pkg::REG_COLS_B:     prdata = {28'd0, cols_b_reg};
            default:                 prdata = '0;
        endcase
    end

    // Input transfers are taken only while no compute runs.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid & ~in_stall;

    // Load path: keep the low element bits of the value, zero above the field.
    assign wr_ext      = {{ELEM_WIDTH{1'b0}}, element_value};
    assign wr_elem     = wr_ext[ELEM_WIDTH-1:0];
    assign wr_in_range = ({1'b0, row_index} < DIM_MAX) && ({1'b0, col_index} < DIM_MAX);
    assign wr_addr     = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));

    always_ff @(posedge clk)
    begin
        if (in_xfer && wr_in_range && (cmd == mmu_pkg::CMD_LOAD_A))
        begin
            store_a[wr_addr] <= wr_elem;
        end
        if (in_xfer && wr_in_range && (cmd == mmu_pkg::CMD_LOAD_B))
        begin
            store_b[wr_addr] <= wr_elem;
        end
    end

    // Read ports: A[i][k] and B[k][j], data registered.
    assign rd_addr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_addr_b = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge clk)
    begin
        rd_a_reg <= store_a[rd_addr_a];
        rd_b_reg <= store_b[rd_addr_b];
    end

    // Loop position flags.
    assign k_last    = ({1'b0, k_reg} == nk_reg - mmu_pkg::DIM_W'(1));
    assign j_last    = ({1'b0, j_reg} == nc_reg - mmu_pkg::DIM_W'(1));
    assign i_last    = ({1'b0, i_reg} == nr_reg - mmu_pkg::DIM_W'(1));
    assign elem_last = i_last & j_last;

    // The output slot is free when empty or emptied at this edge.
    assign out_xfer = out_valid_reg & ~out_stall;
    assign out_free = ~out_valid_reg | out_xfer;

    // Sequencer: one result element at a time, one accumulate step per cycle while it issues.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        nr_next    = nr_reg;
        nk_next    = nk_reg;
        nc_next    = nc_reg;
        issue_ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (cmd == mmu_pkg::CMD_COMPUTE))
                begin
                    nr_next    = clamp_dim(rows_a_reg, DIM_MAX);
                    nk_next    = clamp_dim(inner_size_reg, DIM_MAX);
                    nc_next    = clamp_dim(cols_b_reg, DIM_MAX);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue_ctrl.valid = 1'b1;
                issue_ctrl.first = (k_reg == '0);
                issue_ctrl.last  = k_last;
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + mmu_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    if (elem_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + mmu_pkg::IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + mmu_pkg::IDX_W'(1);
                        end
                        state_next = ST_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            nr_reg      <= mmu_pkg::DIM_W'(1);
            nk_reg      <= mmu_pkg::DIM_W'(1);
            nc_reg      <= mmu_pkg::DIM_W'(1);
            ctrl_rd_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            nr_reg      <= nr_next;
            nk_reg      <= nk_next;
            nc_reg      <= nc_next;
            ctrl_rd_reg <= issue_ctrl;
        end
    end

    // Multiply-accumulate unit, fed by the registered read data.
    mmu_mac #(
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_rd_reg),
        .a     (rd_a_reg),
        .b     (rd_b_reg),
        .done  (mac_done),
        .sum   (mac_sum)
    );

    // Output register: loaded when an element finishes, cleared on transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mac_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_done)
        begin
            result_value_reg <= mac_sum;
            result_row_reg   <= i_reg;
            result_col_reg   <= j_reg;
            last_element_reg <= elem_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign result_row   = result_row_reg;
    assign result_col   = result_col_reg;
    assign last_element = last_element_reg;

endmodule

`default_nettype wire

// File: rtl/mmu_mac.sv
// Two-stage multiply-accumulate unit of the matrix multiply unit.
`default_nettype none

module mmu_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mmu_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [ELEM_WIDTH-1:0]       a,
    input  wire logic signed [ELEM_WIDTH-1:0]       b,
    output logic                                    done,
    output logic signed [mmu_pkg::RES_W-1:0]        sum
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic signed [PROD_W-1:0]          prod_reg;
    mmu_pkg::mac_ctrl_t                ctrl_p_reg;
    logic signed [mmu_pkg::RES_W-1:0]  acc_reg;
    logic signed [mmu_pkg::RES_W-1:0]  acc_next;
    logic signed [mmu_pkg::RES_W-1:0]  prod_ext;
    logic                              done_reg;

    // Product register: the multiplier stands alone in this stage.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // Control follows the product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_p_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctrl_p_reg <= ctrl;
            done_reg   <= ctrl_p_reg.valid & ctrl_p_reg.last;
        end
    end

    // The product is sign-extended or wrapped to the result width; the sum wraps too.
    assign prod_ext = mmu_pkg::RES_W'(prod_reg);

    always_comb
    begin
        if (ctrl_p_reg.first)
        begin
            acc_next = prod_ext;
        end
        else
        begin
            acc_next = acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_p_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

// File: rtl/mmu_checker.sv
// Port-level checker for the matrix multiply unit and its bind.
`default_nettype none
`include "assert_macros.svh"

module mmu_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               pready,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic signed [mmu_pkg::RES_W-1:0]   result_value,
    input wire logic                               last_element
);

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_value), "stalled result changed")

    // While a result other than the last is offered, the compute still runs.
    `ASSERT_IMPL(a_busy_mid, out_valid && !last_element, in_stall, "input open mid-compute")

    // After a result other than the last is taken, more results follow.
    `ASSERT_NEXT(a_busy_after, out_valid && !out_stall && !last_element, in_stall, "compute ended early")

    // The configuration port never waits.
    `ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .last_element (last_element)
);

`default_nettype wire

// File: bench/tb_matrix_multiply_unit.sv
// Self-checking testbench for the matrix multiply unit: a directed script, then random jobs.
module tb_matrix_multiply_unit;

    localparam int MAX_DIM = 8;
    localparam int HALF_PERIOD = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS = 325;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PERCENT = 18;
    localparam longint TIMEOUT = 64'd40_000_000;
    localparam logic [mmu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One element of the product matrix as it leaves the block.
    typedef struct packed {
        logic signed [mmu_pkg::RES_W-1:0] value;
        logic [mmu_pkg::IDX_W-1:0]        row;
        logic [mmu_pkg::IDX_W-1:0]        col;
        logic                             last;
    } product_t;

    typedef enum logic {
        STEP_CONFIG,
        STEP_ITEM
    } step_kind_t;

    // One row of the directed script.
    typedef struct {
        step_kind_t                       kind;
        logic [1:0]                       reg_idx;
        logic [31:0]                      data;
        logic [mmu_pkg::CMD_W-1:0]        op;
        logic [mmu_pkg::IDX_W-1:0]        row;
        logic [mmu_pkg::IDX_W-1:0]        col;
        logic [mmu_pkg::VAL_W-1:0]        value;
        bit                               typed;
        int                               typed_count;
        logic signed [mmu_pkg::RES_W-1:0] typed_value;
    } script_step_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [3:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             in_valid;
    logic                             in_stall;
    logic [mmu_pkg::CMD_W-1:0]        cmd;
    logic [mmu_pkg::IDX_W-1:0]        row_index;
    logic [mmu_pkg::IDX_W-1:0]        col_index;
    logic signed [mmu_pkg::VAL_W-1:0] element_value;
    logic                             out_valid;
    logic                             out_stall;
    logic signed [mmu_pkg::RES_W-1:0] result_value;
    logic [mmu_pkg::IDX_W-1:0]        result_row;
    logic [mmu_pkg::IDX_W-1:0]        result_col;
    logic                             last_element;

    // Shadow copy of the registers and the element stores.
    logic [mmu_pkg::DIM_W-1:0]        rows_reg;
    logic [mmu_pkg::DIM_W-1:0]        inner_reg;
    logic [mmu_pkg::DIM_W-1:0]        cols_reg;
    logic signed [mmu_pkg::VAL_W-1:0] elem_a [MAX_DIM*MAX_DIM];
    logic signed [mmu_pkg::VAL_W-1:0] elem_b [MAX_DIM*MAX_DIM];
    bit                               a_loaded [MAX_DIM*MAX_DIM];
    bit                               b_loaded [MAX_DIM*MAX_DIM];

    product_t     pending_products [$];
    script_step_t script [$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           items_sent = 0;

    matrix_multiply_unit #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_WIDTH(mmu_pkg::VAL_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .row_index    (row_index),
        .col_index    (col_index),
        .element_value(element_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .result_row   (result_row),
        .result_col   (result_col),
        .last_element (last_element)
    );

    always #HALF_PERIOD clk = ~clk;

    // A register value of zero counts as one, anything above the store size as the maximum.
    function automatic int eff_dim(input logic [mmu_pkg::DIM_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_DIM)
            return MAX_DIM;
        return int'(r);
    endfunction

    function automatic int slot(input int r, input int c);
        return r * MAX_DIM + c;
    endfunction

    function automatic void apply_config(input logic [1:0] idx, input logic [31:0] data);
        unique case (idx)
            mmu_pkg::REG_ROWS_A:     rows_reg = data[mmu_pkg::DIM_W-1:0];
            mmu_pkg::REG_INNER_SIZE: inner_reg = data[mmu_pkg::DIM_W-1:0];
            mmu_pkg::REG_COLS_B:     cols_reg = data[mmu_pkg::DIM_W-1:0];
            default:                 ;
        endcase
    endfunction

    // Updates the shadow stores on a load; on a compute queues every product element.
    function automatic void predict_item(input logic [mmu_pkg::CMD_W-1:0] op,
                                         input logic [mmu_pkg::IDX_W-1:0] r,
                                         input logic [mmu_pkg::IDX_W-1:0] c,
                                         input logic [mmu_pkg::VAL_W-1:0] v);
        int       nr;
        int       nk;
        int       nc;
        longint   acc;
        product_t p;
        unique case (op)
            mmu_pkg::CMD_LOAD_A:
            begin
                elem_a[slot(r, c)] = v;
                a_loaded[slot(r, c)] = 1'b1;
            end
            mmu_pkg::CMD_LOAD_B:
            begin
                elem_b[slot(r, c)] = v;
                b_loaded[slot(r, c)] = 1'b1;
            end
            mmu_pkg::CMD_COMPUTE:
            begin
                nr = eff_dim(rows_reg);
                nk = eff_dim(inner_reg);
                nc = eff_dim(cols_reg);
                for (int i = 0; i < nr; i++)
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = 0;
                        for (int k = 0; k < nk; k++)
                        begin
                            acc += longint'(elem_a[slot(i, k)]) * longint'(elem_b[slot(k, j)]);
                        end
                        p.value = acc[mmu_pkg::RES_W-1:0];
                        p.row = mmu_pkg::IDX_W'(i);
                        p.col = mmu_pkg::IDX_W'(j);
                        p.last = (i == nr - 1) && (j == nc - 1);
                        pending_products.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [mmu_pkg::VAL_W-1:0] rand_element();
        unique case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return mmu_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // Mostly small sizes; now and then zero, the maximum or a value above it.
    function automatic logic [mmu_pkg::DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return mmu_pkg::DIM_W'($urandom_range(9, 15));
        if (roll < 24)
            return mmu_pkg::DIM_W'(MAX_DIM);
        return mmu_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    function automatic script_step_t config_step(input logic [1:0] idx, input logic [31:0] data);
        script_step_t s;
        s = '{STEP_CONFIG, idx, data, mmu_pkg::CMD_LOAD_A, '0, '0, '0, 1'b0, 0, '0};
        return s;
    endfunction

    function automatic script_step_t item_step(input logic [mmu_pkg::CMD_W-1:0] op,
                                               input logic [mmu_pkg::IDX_W-1:0] r,
                                               input logic [mmu_pkg::IDX_W-1:0] c,
                                               input logic [mmu_pkg::VAL_W-1:0] v);
        script_step_t s;
        s = '{STEP_ITEM, mmu_pkg::REG_ROWS_A, '0, op, r, c, v, 1'b0, 0, '0};
        return s;
    endfunction

    // An item whose outcome is written out: a single element at the origin, or nothing.
    function automatic script_step_t checked_step(input logic [mmu_pkg::CMD_W-1:0] op,
                                                  input logic [mmu_pkg::IDX_W-1:0] r,
                                                  input logic [mmu_pkg::IDX_W-1:0] c,
                                                  input logic [mmu_pkg::VAL_W-1:0] v,
                                                  input int count,
                                                  input logic signed [mmu_pkg::RES_W-1:0] value);
        script_step_t s;
        s = '{STEP_ITEM, mmu_pkg::REG_ROWS_A, '0, op, r, c, v, 1'b1, count, value};
        return s;
    endfunction

    // Offers one item and holds it until the transfer, then idles at random unless 150 to 229 items are sent.
    task automatic send_item(input logic [mmu_pkg::CMD_W-1:0] op,
                             input logic [mmu_pkg::IDX_W-1:0] r,
                             input logic [mmu_pkg::IDX_W-1:0] c,
                             input logic [mmu_pkg::VAL_W-1:0] v,
                             input bit predicted);
        in_valid <= 1'b1;
        cmd <= op;
        row_index <= r;
        col_index <= c;
        element_value <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (predicted)
            predict_item(op, r, c, v);
        if (op != CMD_UNUSED)
            items_sent++;
        while ((items_sent < 150 || items_sent >= 230) && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Setup cycle, then access cycle; psel stays high so writes can follow back to back.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        apply_config(idx, data);
    endtask

    task automatic cfg_release();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drains every outstanding element, then lets a load still in flight finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [mmu_pkg::DIM_W-1:0] nr,
                            input logic [mmu_pkg::DIM_W-1:0] nk,
                            input logic [mmu_pkg::DIM_W-1:0] nc);
        wait_idle();
        cfg_write(mmu_pkg::REG_ROWS_A, 32'(nr));
        cfg_write(mmu_pkg::REG_INNER_SIZE, 32'(nk));
        cfg_write(mmu_pkg::REG_COLS_B, 32'(nc));
        if ($urandom_range(0, 4) == 0)
            cfg_write(REG_UNUSED, $urandom);
        cfg_release();
    endtask

    task automatic maybe_send_noise();
        if ($urandom_range(0, 99) < 5)
            send_item(CMD_UNUSED, mmu_pkg::IDX_W'($urandom_range(0, 7)),
                      mmu_pkg::IDX_W'($urandom_range(0, 7)), rand_element(), 1'b1);
    endtask

    // A well-formed job: stray loads and unused commands, loads covering what the product reads, compute.
    task automatic run_job();
        int nr;
        int nk;
        int nc;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        repeat ($urandom_range(0, 6))
        begin
            maybe_send_noise();
            send_item($urandom_range(0, 1) ? mmu_pkg::CMD_LOAD_B : mmu_pkg::CMD_LOAD_A,
                      mmu_pkg::IDX_W'($urandom_range(0, 7)),
                      mmu_pkg::IDX_W'($urandom_range(0, 7)),
                      rand_element(), 1'b1);
        end
        for (int i = 0; i < nr; i++)
        begin
            for (int k = 0; k < nk; k++)
            begin
                if (!a_loaded[slot(i, k)] || $urandom_range(0, 7) == 0)
                    send_item(mmu_pkg::CMD_LOAD_A, mmu_pkg::IDX_W'(i), mmu_pkg::IDX_W'(k),
                              rand_element(), 1'b1);
            end
        end
        for (int k = 0; k < nk; k++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                if (!b_loaded[slot(k, j)] || $urandom_range(0, 7) == 0)
                    send_item(mmu_pkg::CMD_LOAD_B, mmu_pkg::IDX_W'(k), mmu_pkg::IDX_W'(j),
                              rand_element(), 1'b1);
            end
        end
        maybe_send_noise();
        send_item(mmu_pkg::CMD_COMPUTE, mmu_pkg::IDX_W'($urandom_range(0, 7)),
                  mmu_pkg::IDX_W'($urandom_range(0, 7)), rand_element(), 1'b1);
    endtask

    // Stimulus: reset, directed script, random jobs, drain.
    initial
    begin
        int           first_random;
        int           phase;
        bit           bus_open;
        script_step_t s;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        cmd <= mmu_pkg::CMD_LOAD_A;
        row_index <= '0;
        col_index <= '0;
        element_value <= '0;
        rows_reg = mmu_pkg::DIM_W'(MAX_DIM);
        inner_reg = mmu_pkg::DIM_W'(MAX_DIM);
        cols_reg = mmu_pkg::DIM_W'(MAX_DIM);

        // Single-element products at the extremes of the element range.
        script.push_back(config_step(mmu_pkg::REG_ROWS_A, 32'hFFFF_FFF1));
        script.push_back(config_step(mmu_pkg::REG_INNER_SIZE, 32'd1));
        script.push_back(config_step(mmu_pkg::REG_COLS_B, 32'd1));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 16'h8000));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 16'h8000));
        script.push_back(checked_step(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1,
                                      35'sd1073741824));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 16'h7FFF));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 16'h7FFF));
        script.push_back(checked_step(mmu_pkg::CMD_COMPUTE, 3'd7, 3'd7, 16'hFFFF, 1,
                                      35'sd1073676289));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 16'h8000));
        script.push_back(checked_step(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1,
                                      -35'sd1073709056));
        // The unused command and loads at the far corner produce nothing.
        script.push_back(checked_step(CMD_UNUSED, 3'd7, 3'd7, 16'hFFFF, 0, '0));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd7, 3'd7, 16'hFFFF));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd7, 3'd7, 16'h0000));
        // Zero sizes count as one; a write to a register that does not exist is dropped.
        script.push_back(config_step(mmu_pkg::REG_ROWS_A, 32'd0));
        script.push_back(config_step(mmu_pkg::REG_INNER_SIZE, 32'd0));
        script.push_back(config_step(mmu_pkg::REG_COLS_B, 32'd0));
        script.push_back(config_step(REG_UNUSED, 32'd5));
        script.push_back(checked_step(mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1,
                                      -35'sd1073709056));
        // A small full product.
        script.push_back(config_step(mmu_pkg::REG_ROWS_A, 32'd2));
        script.push_back(config_step(mmu_pkg::REG_INNER_SIZE, 32'd2));
        script.push_back(config_step(mmu_pkg::REG_COLS_B, 32'd2));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd0, 16'h0001));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd0, 3'd1, 16'hFFFF));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd1, 3'd0, 16'd300));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_A, 3'd1, 3'd1, 16'h7FFF));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd0, 16'h8000));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd0, 3'd1, 16'h0002));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd1, 3'd0, 16'hFFFB));
        script.push_back(item_step(mmu_pkg::CMD_LOAD_B, 3'd1, 3'd1, 16'h7FFF));
        script.push_back(item_step(mmu_pkg::CMD_COMPUTE, 3'd5, 3'd2, 16'h1234));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed script; consecutive register writes share one bus session.
        bus_open = 1'b0;
        foreach (script[n])
        begin
            s = script[n];
            if (s.kind == STEP_CONFIG)
            begin
                if (!bus_open)
                    wait_idle();
                cfg_write(s.reg_idx, s.data);
                bus_open = 1'b1;
            end
            else
            begin
                if (bus_open)
                begin
                    cfg_release();
                    bus_open = 1'b0;
                end
                if (s.typed)
                begin
                    repeat (s.typed_count)
                        pending_products.push_back('{s.typed_value, 3'd0, 3'd0, 1'b1});
                end
                send_item(s.op, s.row, s.col, s.value, !s.typed);
            end
        end

        // Random jobs; the first phase uses a saturated row count and the largest inner size.
        first_random = items_sent;
        phase = 0;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if (phase == 0)
                set_dims(4'd15, mmu_pkg::DIM_W'(MAX_DIM), 4'd2);
            else
                set_dims(pick_dim(), pick_dim(), pick_dim());
            repeat ($urandom_range(1, 3)) run_job();
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: checks each transfer against the oldest expected element, stalls at random.
    initial
    begin
        int       hold_left;
        bit       held;
        product_t want;
        hold_left = 0;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                results_seen++;
                if (pending_products.size() == 0)
                begin
                    $error("result_value: no element expected, got %0d at row %0d col %0d",
                           result_value, result_row, result_col);
                    mismatches++;
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d", want.value, result_value);
                        mismatches++;
                    end
                    if (result_row !== want.row)
                    begin
                        $error("result_row: expected %0d, got %0d", want.row, result_row);
                        mismatches++;
                    end
                    if (result_col !== want.col)
                    begin
                        $error("result_col: expected %0d, got %0d", want.col, result_col);
                        mismatches++;
                    end
                    if (last_element !== want.last)
                    begin
                        $error("last_element: expected %0d, got %0d", want.last, last_element);
                        mismatches++;
                    end
                end
            end
            // One long hold-off while items keep arriving, so the block backs up.
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held && results_seen >= 60 && in_valid)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (results_seen < 200 || results_seen >= 330) &&
                             ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Guard against a hung run.
    initial
    begin
        #(TIMEOUT);
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: matrix_multiply_unit.f
+incdir+rtl
rtl/mmu_pkg.sv
rtl/mmu_mac.sv
rtl/matrix_multiply_unit.sv
rtl/mmu_checker.sv
bench/tb_matrix_multiply_unit.sv
